// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, quiet while reset is held.
`define DETQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define DETQ_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- rtl/detq_pkg.sv -----
// Types, codes and helpers of the delayed event timer queue.
package detq_pkg;

    localparam int DEFAULT_DEPTH = 16;
    localparam int MAX_FIRE      = 16;

    localparam logic [2:0] OP_SCHED       = 3'd0;
    localparam logic [2:0] OP_CANCEL_ID   = 3'd1;
    localparam logic [2:0] OP_CANCEL_SESS = 3'd2;
    localparam logic [2:0] OP_TICK        = 3'd3;
    localparam logic [2:0] OP_QUERY       = 3'd4;

    localparam logic [1:0] KIND_ANSWER = 2'd0;
    localparam logic [1:0] KIND_FIRED  = 2'd1;
    localparam logic [1:0] KIND_NONE   = 2'd2;

    typedef struct packed {
        logic [2:0]  operation;
        logic [7:0]  event_id;
        logic [7:0]  owner_session;
        logic [15:0] delay_ticks;
        logic [15:0] payload_tag;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic        ok;
        logic [7:0]  fired_id;
        logic [7:0]  fired_session;
        logic [15:0] fired_tag;
        logic [4:0]  removed_count;
        logic [4:0]  pending_count;
        logic        table_full;
        logic        last;
    } t_out_item;

    // Classified command handed from front to back.
    typedef struct packed {
        logic [2:0]  op;
        logic        known;
        logic        id_nz;
        logic        sess_nz;
        logic [7:0]  event_id;
        logic [7:0]  owner_session;
        logic [15:0] delay_ticks;
        logic [15:0] payload_tag;
    } t_cmd;

    typedef struct packed {
        logic [7:0]  id;
        logic [7:0]  sess;
        logic [31:0] due;
        logic [31:0] stamp;
        logic [15:0] tag;
    } t_entry;

    function automatic logic [4:0] sat31(input logic [31:0] v);
        return (v > 32'd31) ? 5'd31 : v[4:0];
    endfunction

    function automatic logic [4:0] min_fire(input logic [31:0] v);
        return (v > 32'(MAX_FIRE)) ? 5'(MAX_FIRE) : v[4:0];
    endfunction

endpackage

// ----- rtl/detq_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
module detq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- rtl/detq_fifo.sv -----
// Small register queue used for commands and for results.
module detq_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    output logic             o_empty,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end
endmodule

// ----- rtl/detq_front.sv -----
// Front end: takes input items, classifies them and queues commands.
module detq_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  detq_pkg::t_in_item i_item,
    output logic              o_full,
    output logic              o_cmd_vld,
    output detq_pkg::t_cmd    o_cmd,
    input  logic              i_cmd_pop
);
    import detq_pkg::*;

    t_cmd w_cmd;
    logic w_empty;

    always_comb begin
        w_cmd.op            = i_item.operation;
        w_cmd.known         = (i_item.operation == OP_SCHED)
                           || (i_item.operation == OP_CANCEL_ID)
                           || (i_item.operation == OP_CANCEL_SESS)
                           || (i_item.operation == OP_TICK)
                           || (i_item.operation == OP_QUERY);
        w_cmd.id_nz         = (i_item.event_id != 8'd0);
        w_cmd.sess_nz       = (i_item.owner_session != 8'd0);
        w_cmd.event_id      = i_item.event_id;
        w_cmd.owner_session = i_item.owner_session;
        w_cmd.delay_ticks   = i_item.delay_ticks;
        w_cmd.payload_tag   = i_item.payload_tag;
    end

    detq_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (2)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_wdata (w_cmd),
        .o_full  (o_full),
        .o_empty (w_empty),
        .i_pop   (i_cmd_pop),
        .o_rdata (o_cmd)
    );

    assign o_cmd_vld = !w_empty;
endmodule

// ----- rtl/detq_back.sv -----
// Back end: runs each known command against the event table by scanning it.
module detq_back #(
    parameter int TABLE_DEPTH = detq_pkg::DEFAULT_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_vld,
    input  detq_pkg::t_cmd      i_cmd,
    output logic                o_cmd_pop,
    output logic                o_res_push,
    output detq_pkg::t_out_item o_res,
    input  logic                i_res_full
);
    import detq_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0]             r_state;
    t_cmd                   r_cmd;
    logic [TABLE_DEPTH-1:0] r_valid;
    logic [CNT_W-1:0]       r_live;
    logic [31:0]            r_now;
    logic [31:0]            r_stamp;

    logic             r_issue;
    logic [IDX_W-1:0] r_addr;
    logic             r_p_vld;
    logic [IDX_W-1:0] r_p_idx;

    logic             r_hit;
    logic [IDX_W-1:0] r_hit_idx;
    logic [7:0]       r_hit_sess;
    logic             r_free_f;
    logic [IDX_W-1:0] r_free_idx;
    logic [CNT_W-1:0] r_cnt;

    logic             r_fire_pass;
    logic [4:0]       r_remaining;
    logic             r_best_f;
    logic [IDX_W-1:0] r_best_idx;
    logic [31:0]      r_best_age;
    logic [31:0]      r_best_stamp;
    t_entry           r_best;

    t_out_item r_res;
    logic      r_more;
    t_out_item n_res;
    logic      n_more;

    t_entry           w_rdata;
    t_entry           w_wdata;
    logic             w_we;
    logic [IDX_W-1:0] w_slot;
    logic             w_sched_ok;
    logic             w_p_valid;
    logic             w_id_hit;
    logic [31:0]      w_age;
    logic             w_due;
    logic [31:0]      w_ord_diff;
    logic             w_better;
    logic             w_cancel_ok;
    logic [4:0]       w_fires;
    logic             w_rescan;

    assign o_cmd_pop  = (r_state == S_IDLE) && i_cmd_vld;
    assign o_res_push = (r_state == S_EMIT) && !i_res_full;

    always_comb begin
        o_res               = r_res;
        o_res.pending_count = sat31(32'(r_live));
    end

    always_comb begin
        w_p_valid   = r_valid[r_p_idx];
        w_id_hit    = w_p_valid && r_cmd.id_nz && (w_rdata.id == r_cmd.event_id);
        w_age       = r_now - w_rdata.due;
        w_due       = w_p_valid && !w_age[31];
        w_ord_diff  = w_rdata.stamp - r_best_stamp;
        w_better    = !r_best_f || (w_age > r_best_age)
                   || ((w_age == r_best_age) && w_ord_diff[31]);
        w_slot      = r_hit ? r_hit_idx : r_free_idx;
        w_sched_ok  = r_cmd.id_nz && (r_hit || r_free_f);
        w_we        = (r_state == S_FIN) && (r_cmd.op == OP_SCHED) && w_sched_ok;
        w_cancel_ok = r_hit && (!r_cmd.sess_nz || (r_hit_sess == r_cmd.owner_session));
        w_fires     = min_fire(32'(r_cnt));
        w_rescan    = (r_cmd.op == OP_TICK) && !r_fire_pass && (w_fires != 5'd0);
        w_wdata.id    = r_cmd.event_id;
        w_wdata.sess  = r_cmd.owner_session;
        w_wdata.due   = r_now + 32'(r_cmd.delay_ticks);
        w_wdata.stamp = r_stamp;
        w_wdata.tag   = r_cmd.payload_tag;
    end

    // Build the result that the current state hands to the result queue.
    always_comb begin
        n_res      = '0;
        n_res.kind = KIND_ANSWER;
        n_res.last = 1'b1;
        n_more     = 1'b0;
        if (r_state == S_FIN) begin
            case (r_cmd.op)
                OP_SCHED: begin
                    n_res.ok         = w_sched_ok;
                    n_res.table_full = r_cmd.id_nz && !r_hit && !r_free_f;
                end
                OP_CANCEL_ID: begin
                    n_res.ok = w_cancel_ok;
                end
                OP_CANCEL_SESS: begin
                    n_res.ok            = (r_cnt != '0);
                    n_res.removed_count = sat31(32'(r_cnt));
                end
                OP_QUERY: begin
                    n_res.ok = r_hit;
                end
                OP_TICK: begin
                    if (!r_fire_pass) begin
                        if (w_fires == 5'd0) begin
                            n_res.kind = KIND_NONE;
                        end
                    end else begin
                        n_res.kind          = KIND_FIRED;
                        n_res.fired_id      = r_best.id;
                        n_res.fired_session = r_best.sess;
                        n_res.fired_tag     = r_best.tag;
                        n_res.last          = (r_remaining == 5'd1);
                        n_more              = (r_remaining != 5'd1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    detq_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_slot),
        .i_wdata (w_wdata),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            r_live   <= '0;
            r_now    <= '0;
            r_stamp  <= '0;
            r_issue  <= 1'b0;
            r_p_vld  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_vld) begin
                        r_cmd       <= i_cmd;
                        r_hit       <= 1'b0;
                        r_free_f    <= 1'b0;
                        r_best_f    <= 1'b0;
                        r_cnt       <= '0;
                        r_fire_pass <= 1'b0;
                        if (i_cmd.op == OP_TICK) begin
                            r_now <= r_now + 32'd1;
                        end
                        if (i_cmd.known) begin
                            r_addr  <= '0;
                            r_issue <= 1'b1;
                            r_p_vld <= 1'b0;
                            r_state <= S_SCAN;
                        end else begin
                            r_res   <= n_res;
                            r_more  <= n_more;
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_SCAN: begin
                    // issue one table read per cycle, look at its data in the next cycle
                    if (r_issue) begin
                        r_p_vld <= 1'b1;
                        r_p_idx <= r_addr;
                        if (r_addr == LAST_IDX) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_addr <= r_addr + 1'b1;
                        end
                    end else begin
                        r_p_vld <= 1'b0;
                    end
                    if (r_p_vld) begin
                        case (r_cmd.op)
                            OP_SCHED, OP_CANCEL_ID, OP_QUERY: begin
                                if (w_id_hit) begin
                                    r_hit      <= 1'b1;
                                    r_hit_idx  <= r_p_idx;
                                    r_hit_sess <= w_rdata.sess;
                                end
                                if (!w_p_valid && !r_free_f) begin
                                    r_free_f   <= 1'b1;
                                    r_free_idx <= r_p_idx;
                                end
                            end
                            OP_CANCEL_SESS: begin
                                if (w_p_valid && r_cmd.sess_nz
                                        && (w_rdata.sess == r_cmd.owner_session)) begin
                                    r_valid[r_p_idx] <= 1'b0;
                                    r_live           <= r_live - 1'b1;
                                    r_cnt            <= r_cnt + 1'b1;
                                end
                            end
                            OP_TICK: begin
                                if (w_due && !r_fire_pass) begin
                                    r_cnt <= r_cnt + 1'b1;
                                end
                                if (w_due && r_fire_pass && w_better) begin
                                    r_best_f     <= 1'b1;
                                    r_best_idx   <= r_p_idx;
                                    r_best_age   <= w_age;
                                    r_best_stamp <= w_rdata.stamp;
                                    r_best       <= w_rdata;
                                end
                            end
                            default: begin
                            end
                        endcase
                        if (r_p_idx == LAST_IDX) begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_FIN: begin
                    r_res   <= n_res;
                    r_more  <= n_more;
                    r_state <= w_rescan ? S_SCAN : S_EMIT;
                    case (r_cmd.op)
                        OP_SCHED: begin
                            if (w_sched_ok) begin
                                r_valid[w_slot] <= 1'b1;
                                r_stamp         <= r_stamp + 32'd1;
                                if (!r_hit) begin
                                    r_live <= r_live + 1'b1;
                                end
                            end
                        end
                        OP_CANCEL_ID: begin
                            if (w_cancel_ok) begin
                                r_valid[r_hit_idx] <= 1'b0;
                                r_live             <= r_live - 1'b1;
                            end
                        end
                        OP_TICK: begin
                            if (!r_fire_pass) begin
                                if (w_rescan) begin
                                    // count the whole tick now so every result shows the end state
                                    r_remaining <= w_fires;
                                    r_live      <= r_live - CNT_W'(w_fires);
                                    r_fire_pass <= 1'b1;
                                    r_best_f    <= 1'b0;
                                    r_addr      <= '0;
                                    r_issue     <= 1'b1;
                                    r_p_vld     <= 1'b0;
                                end
                            end else begin
                                r_valid[r_best_idx] <= 1'b0;
                                r_remaining         <= r_remaining - 5'd1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                S_EMIT: begin
                    if (!i_res_full) begin
                        if (r_more) begin
                            r_best_f <= 1'b0;
                            r_addr   <= '0;
                            r_issue  <= 1'b1;
                            r_p_vld  <= 1'b0;
                            r_state  <= S_SCAN;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule

// ----- rtl/delayed_event_timer_queue.sv -----
// Top level of the delayed event timer queue.
// Commands enter a two-deep command queue and run one at a time against a
// TABLE_DEPTH-entry event table held in a RAM with one read port. Each known
// command takes one full scan of that port before its answer goes to the
// two-deep result queue; an unknown one is answered without a scan. A tick that
// fires k events takes k + 1 scans: one to count what is due, then one per
// fired event to find the earliest. Results leave in order; a full result
// queue holds the table engine until popped.
module delayed_event_timer_queue #(
    parameter int TABLE_DEPTH = detq_pkg::DEFAULT_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    input  detq_pkg::t_in_item  i_item,
    output logic                full,
    output logic                empty,
    input  logic                pop,
    output detq_pkg::t_out_item o_res
);
    import detq_pkg::*;

    logic      w_cmd_vld;
    t_cmd      w_cmd;
    logic      w_cmd_pop;
    logic      w_res_push;
    t_out_item w_res;
    logic      w_res_full;

    detq_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_item    (i_item),
        .o_full    (full),
        .o_cmd_vld (w_cmd_vld),
        .o_cmd     (w_cmd),
        .i_cmd_pop (w_cmd_pop)
    );

    detq_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_vld  (w_cmd_vld),
        .i_cmd      (w_cmd),
        .o_cmd_pop  (w_cmd_pop),
        .o_res_push (w_res_push),
        .o_res      (w_res),
        .i_res_full (w_res_full)
    );

    detq_fifo #(
        .WIDTH ($bits(t_out_item)),
        .DEPTH (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_wdata (w_res),
        .o_full  (w_res_full),
        .o_empty (empty),
        .i_pop   (pop),
        .o_rdata (o_res)
    );
endmodule

// ----- rtl/detq_checker.sv -----
// Port-level checks of the delayed event timer queue, bound to the top level.
`include "assert_macros.svh"

module detq_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                empty,
    input detq_pkg::t_out_item o_res
);
    import detq_pkg::*;

    logic w_shown;
    logic w_evt_zero;

    assign w_shown    = !empty;
    assign w_evt_zero = (o_res.fired_id == 8'd0) && (o_res.fired_session == 8'd0)
                     && (o_res.fired_tag == 16'd0);

    `DETQ_ASSERT_RST(a_empty_after_reset, !i_rst_n |=> empty, "results present after reset")
    `DETQ_ASSERT(a_kind_legal, w_shown |-> (o_res.kind != 2'd3), "illegal result kind")
    `DETQ_ASSERT(a_fields_zero, (w_shown && (o_res.kind != KIND_FIRED)) |-> w_evt_zero, "event fields set")
    `DETQ_ASSERT(a_full_refused, (w_shown && o_res.table_full) |-> !o_res.ok, "table full with success")
    `DETQ_ASSERT(a_none_last, (w_shown && (o_res.kind == KIND_NONE)) |-> o_res.last, "idle tick not last")
endmodule

bind delayed_event_timer_queue detq_checker u_detq_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .empty   (empty),
    .o_res   (o_res)
);

// ----- test/tb_delayed_event_timer_queue.sv -----
// Self-checking testbench of the delayed event timer queue.
module tb_delayed_event_timer_queue;
    timeunit 1ns;
    timeprecision 1ps;

    import detq_pkg::*;

    localparam int DEPTH      = 16;
    localparam int IDLE_LIMIT = 20000;
    localparam int N_RANDOM   = 334;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      push = 1'b0;
    t_in_item  i_item = '0;
    logic      full;
    logic      empty;
    logic      pop = 1'b0;
    t_out_item o_res;

    delayed_event_timer_queue #(.TABLE_DEPTH(DEPTH)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .i_item(i_item),
        .full(full), .empty(empty), .pop(pop), .o_res(o_res)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the event table.
    logic        tm_valid [DEPTH];
    logic [7:0]  tm_id    [DEPTH];
    logic [7:0]  tm_sess  [DEPTH];
    logic [31:0] tm_due   [DEPTH];
    logic [31:0] tm_stamp [DEPTH];
    logic [15:0] tm_tag   [DEPTH];
    logic [31:0] tm_now;
    logic [31:0] tm_stamp_next;

    t_out_item   pending_results[$];
    int          n_errors = 0;
    int          idle_cycles = 0;
    int          pop_gap = 0;
    bit          quiet = 1'b0;
    bit          done = 1'b0;

    typedef struct {
        t_in_item  stim;
        bit        has_want;
        t_out_item want;
    } t_row;

    t_row rows[$];

    task automatic report(input string what, input t_out_item got, input t_out_item want);
        n_errors++;
        $display("MISMATCH %s: got %p want %p", what, got, want);
    endtask

    task automatic add_row(input t_in_item stim, input bit has_want, input t_out_item want);
        rows = {rows, t_row'{stim, has_want, want}};
    endtask

    function automatic int find_slot(input logic [7:0] id);
        for (int i = 0; i < DEPTH; i++)
            if (tm_valid[i] && tm_id[i] == id) return i;
        return -1;
    endfunction

    function automatic t_out_item answer(input logic ok, input logic [4:0] removed,
                                         input logic tfull);
        t_out_item r;
        r = '0;
        r.kind = KIND_ANSWER;
        r.ok = ok;
        r.removed_count = removed;
        r.table_full = tfull;
        return r;
    endfunction

    // Apply one command to the shadow table and queue what it should produce.
    task automatic predict_timer_results(input t_in_item it);
        t_out_item outs[$];
        t_out_item r;
        int        slot, best, live;
        logic [31:0] age, best_age;
        int        removed;
        case (it.operation)
            OP_SCHED: begin
                slot = -1;
                if (it.event_id != 0) begin
                    slot = find_slot(it.event_id);
                    if (slot < 0)
                        for (int i = 0; i < DEPTH; i++)
                            if (!tm_valid[i] && slot < 0) slot = i;
                end
                if (it.event_id == 0) outs = {outs, answer(1'b0, 5'd0, 1'b0)};
                else if (slot < 0) outs = {outs, answer(1'b0, 5'd0, 1'b1)};
                else begin
                    tm_valid[slot] = 1'b1;
                    tm_id[slot] = it.event_id;
                    tm_sess[slot] = it.owner_session;
                    tm_due[slot] = tm_now + 32'(it.delay_ticks);
                    tm_stamp[slot] = tm_stamp_next;
                    tm_tag[slot] = it.payload_tag;
                    tm_stamp_next++;
                    outs = {outs, answer(1'b1, 5'd0, 1'b0)};
                end
            end
            OP_CANCEL_ID: begin
                slot = (it.event_id != 0) ? find_slot(it.event_id) : -1;
                if (slot >= 0 && (it.owner_session == 0 || tm_sess[slot] == it.owner_session)) begin
                    tm_valid[slot] = 1'b0;
                    outs = {outs, answer(1'b1, 5'd0, 1'b0)};
                end else
                    outs = {outs, answer(1'b0, 5'd0, 1'b0)};
            end
            OP_CANCEL_SESS: begin
                removed = 0;
                if (it.owner_session != 0)
                    for (int i = 0; i < DEPTH; i++)
                        if (tm_valid[i] && tm_sess[i] == it.owner_session) begin
                            tm_valid[i] = 1'b0;
                            removed++;
                        end
                outs = {outs, answer(removed > 0, 5'(removed), 1'b0)};
            end
            OP_TICK: begin
                tm_now++;
                while (outs.size() < MAX_FIRE) begin
                    best = -1;
                    best_age = '0;
                    for (int i = 0; i < DEPTH; i++) begin
                        age = tm_now - tm_due[i];
                        if (tm_valid[i] && !age[31]) begin
                            if (best < 0 || age > best_age ||
                                (age == best_age && ((tm_stamp[i] - tm_stamp[best]) >> 31))) begin
                                best = i;
                                best_age = age;
                            end
                        end
                    end
                    if (best < 0) break;
                    tm_valid[best] = 1'b0;
                    r = '0;
                    r.kind = KIND_FIRED;
                    r.fired_id = tm_id[best];
                    r.fired_session = tm_sess[best];
                    r.fired_tag = tm_tag[best];
                    outs = {outs, r};
                end
                if (outs.size() == 0) begin
                    r = '0;
                    r.kind = KIND_NONE;
                    outs = {outs, r};
                end
            end
            OP_QUERY:
                outs = {outs, answer(it.event_id != 0 && find_slot(it.event_id) >= 0,
                                     5'd0, 1'b0)};
            default: outs = {outs, answer(1'b0, 5'd0, 1'b0)};
        endcase
        live = 0;
        for (int i = 0; i < DEPTH; i++) if (tm_valid[i]) live++;
        foreach (outs[k]) begin
            outs[k].pending_count = 5'(live);
            outs[k].last = (k == outs.size() - 1);
            pending_results = {pending_results, outs[k]};
        end
    endtask

    task automatic send(input t_in_item it);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (full);
        predict_timer_results(it);
    endtask

    function automatic t_in_item mk(input logic [2:0] op, input logic [7:0] id,
                                    input logic [7:0] sess, input logic [15:0] dly,
                                    input logic [15:0] tag);
        t_in_item it;
        it.operation = op;
        it.event_id = id;
        it.owner_session = sess;
        it.delay_ticks = dly;
        it.payload_tag = tag;
        return it;
    endfunction

    // Result side: pop stalls in random bursts (never while quiet), compare against the oldest
    // expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (pending_results.size() == 0)
                report("unexpected result", o_res, '0);
            else begin
                if (o_res !== pending_results[0])
                    report("result", o_res, pending_results[0]);
                void'(pending_results.pop_front());
            end
        end
        if (!i_rst_n) begin
            pop <= 1'b0;
            pop_gap <= 0;
        end else if (quiet) begin
            pop <= 1'b1;
            pop_gap <= 0;
        end else if (pop_gap > 1) begin
            pop <= 1'b0;
            pop_gap <= pop_gap - 1;
        end else if (pop_gap == 1) begin
            // end of a stall burst: take at least one transfer slot
            pop <= 1'b1;
            pop_gap <= 0;
        end else if ($urandom_range(0, 4) == 0) begin
            pop <= 1'b0;
            pop_gap <= $urandom_range(1, 3);
        end else
            pop <= 1'b1;
    end

    // Watchdog: count cycles with no transfer on either side.
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        t_row      rw;
        t_in_item  it;
        int        kind_pick;
        for (int i = 0; i < DEPTH; i++) begin
            tm_valid[i] = 1'b0;
            tm_id[i] = '0; tm_sess[i] = '0; tm_due[i] = '0; tm_stamp[i] = '0; tm_tag[i] = '0;
        end
        tm_now = '0;
        tm_stamp_next = '0;

        // Directed rows; expectations typed in only for obvious answers.
        rw.has_want = 1'b1;
        rw.want = '0; rw.want.kind = KIND_NONE; rw.want.last = 1'b1;
        rw.stim = mk(OP_TICK, 8'd0, 8'd0, 16'd0, 16'd0); add_row(rw.stim, 1'b1, rw.want);
        rw.want = '0; rw.want.last = 1'b1;
        rw.stim = mk(OP_SCHED, 8'd0, 8'd5, 16'd3, 16'h1234); add_row(rw.stim, 1'b1, rw.want);
        rw.stim = mk(OP_QUERY, 8'd0, 8'd0, 16'd0, 16'd0); add_row(rw.stim, 1'b1, rw.want);
        rw.stim = mk(OP_CANCEL_SESS, 8'd0, 8'd0, 16'd0, 16'd0); add_row(rw.stim, 1'b1, rw.want);
        rw.stim = mk(3'd5, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF); add_row(rw.stim, 1'b1, rw.want);
        rw.stim = mk(3'd7, 8'hAA, 8'h55, 16'hAAAA, 16'h5555); add_row(rw.stim, 1'b1, rw.want);
        add_row(mk(OP_SCHED, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF), 1'b0, '0);
        add_row(mk(OP_SCHED, 8'd1, 8'd1, 16'd0, 16'h0001), 1'b0, '0);
        add_row(mk(OP_SCHED, 8'd2, 8'd2, 16'd1, 16'h0002), 1'b0, '0);
        add_row(mk(OP_SCHED, 8'd3, 8'd0, 16'd1, 16'h0003), 1'b0, '0);
        add_row(mk(OP_SCHED, 8'd1, 8'd1, 16'd1, 16'h0011), 1'b0, '0);
        add_row(mk(OP_QUERY, 8'd2, 8'd0, 16'd0, 16'd0), 1'b0, '0);
        add_row(mk(OP_CANCEL_ID, 8'd2, 8'd9, 16'd0, 16'd0), 1'b0, '0);
        add_row(mk(OP_TICK, 8'd0, 8'd0, 16'd0, 16'd0), 1'b0, '0);
        // fill the table, then overflow it
        for (int i = 0; i < DEPTH + 1; i++)
            add_row(mk(OP_SCHED, 8'(16 + i), 8'(i % 3 + 1), 16'(i % 2), 16'(i)), 1'b0, '0);
        add_row(mk(OP_SCHED, 8'd99, 8'd1, 16'd0, 16'd0), 1'b0, '0);
        add_row(mk(OP_CANCEL_ID, 8'd16, 8'd0, 16'd0, 16'd0), 1'b0, '0);
        add_row(mk(OP_CANCEL_SESS, 8'd0, 8'd2, 16'd0, 16'd0), 1'b0, '0);
        add_row(mk(OP_TICK, 8'd0, 8'd0, 16'd0, 16'd0), 1'b0, '0);
        add_row(mk(OP_TICK, 8'd0, 8'd0, 16'd0, 16'd0), 1'b0, '0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[r]) begin
            if (rows[r].has_want) begin
                send(rows[r].stim);
                if (pending_results[$] !== rows[r].want)
                    report("directed", pending_results[$], rows[r].want);
            end else
                send(rows[r].stim);
        end

        // Random part: small id and session pools so hits, replaces and ties occur.
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n > N_RANDOM - 40) quiet = 1'b1;
            it.event_id = (($urandom_range(0, 15) == 0) ? 8'($urandom) :
                           8'($urandom_range(0, 24)));
            it.owner_session = (($urandom_range(0, 15) == 0) ? 8'($urandom) :
                                8'($urandom_range(0, 4)));
            it.delay_ticks = (($urandom_range(0, 19) == 0) ? 16'($urandom) :
                              16'($urandom_range(0, 6)));
            it.payload_tag = 16'($urandom);
            kind_pick = $urandom_range(0, 99);
            if (kind_pick < 40) it.operation = OP_SCHED;
            else if (kind_pick < 52) it.operation = OP_CANCEL_ID;
            else if (kind_pick < 58) it.operation = OP_CANCEL_SESS;
            else if (kind_pick < 85) it.operation = OP_TICK;
            else if (kind_pick < 97) it.operation = OP_QUERY;
            else it.operation = 3'($urandom_range(5, 7));
            send(it);
        end
        push <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4 * (DEPTH + 4)) @(posedge i_clk);
        if (n_errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/detq_pkg.sv
rtl/detq_ram.sv
rtl/detq_fifo.sv
rtl/detq_front.sv
rtl/detq_back.sv
rtl/delayed_event_timer_queue.sv
rtl/detq_checker.sv
test/tb_delayed_event_timer_queue.sv
